[hw/rtl/extended_gcd_top_assert.svh]
// Assertion macros for the extended gcd block.
`ifndef EXTENDED_GCD_TOP_ASSERT_SVH
`define EXTENDED_GCD_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EGCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egcd: check failed");

// Next-cycle implication, checked outside reset.
`define EGCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egcd: check failed");

`endif

[hw/rtl/egcd_pkg.sv]
// Shared widths and item types for the extended gcd block.
package egcd_pkg;

  localparam int DATA_W = 31;
  localparam int COEF_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef struct packed {
    logic [DATA_W-1:0] a_value;
    logic [DATA_W-1:0] b_value;
  } egcd_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]        gcd_value;
    logic signed [COEF_W-1:0] coef_x;
    logic signed [COEF_W-1:0] coef_y;
  } egcd_out_t;

endpackage

[hw/rtl/extended_gcd_top.sv]
// Extended Euclid engine: gcd and Bezout coefficients on a shared divider and multiplier.
//
//   channel | ports                        | item
//   --------+------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data  | a_value, b_value
//   result  | out_valid, out_stall, out_data | gcd_value, coef_x, coef_y
//
// One Euclid step runs a zero check, then the restoring divider (one
// quotient bit a cycle), then two products on the shared multiplier and
// one update. in_stall is high while an item is in flight. Reset clears
// control only. The result register lets the next item start while a
// result waits under out_stall.
module extended_gcd_top
  import egcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  egcd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output egcd_out_t out_data
);

`include "extended_gcd_top_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MULX  = 3'd3;
  localparam logic [2:0] ST_MULY  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] num_r, num_nxt;     // shrinking divisor
  logic [DATA_W-1:0] den_r, den_nxt;     // ends as the gcd
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;     // dividend shifts out, quotient in
  logic [COEF_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [COEF_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [COEF_W-1:0] prodx_r, prodx_nxt, prody_r, prody_nxt;
  logic              out_valid_r, out_valid_nxt;
  egcd_out_t         out_data_r, out_data_nxt;

  logic [DATA_W:0]   div_shift;
  logic [DATA_W:0]   div_diff;
  logic [COEF_W-1:0] mul_a, mul_b, mul_p;

  // restoring divider step
  assign div_shift = {rem_r, quo_r[DATA_W-1]};
  assign div_diff  = div_shift - {1'b0, num_r};

  // shared multiplier, kept modulo 2^COEF_W
  assign mul_a = COEF_W'(quo_r);
  assign mul_b = (state_r == ST_MULX) ? cx_r : cy_r;
  assign mul_p = COEF_W'(mul_a * mul_b);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    prodx_nxt     = prodx_r;
    prody_nxt     = prody_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          num_nxt   = in_data.a_value;
          den_nxt   = in_data.b_value;
          cx_nxt    = COEF_W'(1);
          cy_nxt    = '0;
          px_nxt    = '0;
          py_nxt    = COEF_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (num_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = den_r;
          cnt_nxt   = CNT_W'(DATA_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_diff[DATA_W]) begin
          rem_nxt = div_diff[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = ST_MULX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MULX: begin
        prodx_nxt = mul_p;
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        prody_nxt = mul_p;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        px_nxt    = cx_r;
        py_nxt    = cy_r;
        cx_nxt    = px_r - prodx_r;
        cy_nxt    = py_r - prody_r;
        den_nxt   = num_r;
        num_nxt   = rem_r;
        state_nxt = ST_CHECK;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.gcd_value = den_r;
          out_data_nxt.coef_x    = px_r;
          out_data_nxt.coef_y    = py_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    prodx_r    <= prodx_nxt;
    prody_r    <= prody_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `EGCD_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_CHECK)
  `EGCD_ASSERT_NOW(a_div_nonzero, state_r == ST_DIV, num_r != '0)
  `EGCD_ASSERT_NOW(a_rem_bound, state_r == ST_UPD, rem_r < num_r)
  `EGCD_ASSERT_NOW(a_fin_done, state_r == ST_FIN, num_r == '0)

endmodule
